/* hdl/iee_pkg.sv */
// Shared types, constants and helper functions for the infix expression evaluator.
package iee_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         error;
    } t_out;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_DIV0      = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_MALFORMED = 3'd3,
        ERR_BADCHAR   = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_SPACE,
        CLS_LINE_END,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_OPER,
        CLS_BAD
    } t_cls;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_SECOND,
        RD_ZERO
    } t_rdsel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FLUSH,
        ST_DISPATCH,
        ST_OP_CHK,
        ST_OP_RD,
        ST_OPUSH,
        ST_CL_CHK,
        ST_CL_RD,
        ST_FIN,
        ST_FN_CHK,
        ST_FN_RD,
        ST_FIN_END,
        ST_FIN_RD,
        ST_AP_CHK,
        ST_AP_RB,
        ST_AP_RA,
        ST_AP_EXE,
        ST_AP_DIV,
        ST_AP_PUSH
    } t_state;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic   load_in;
        logic   accum;
        logic   load_code;
        logic   flush;
        logic   optr_push;
        logic   optr_pop;
        t_rdsel rd_sel;
        logic   lat_b;
        logic   lat_a;
        logic   opnd_pop2;
        logic   exec;
        logic   div_start;
        logic   res_push;
        t_err   raise;
        logic   out_load;
        logic   clr_all;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic last;
        logic err_set;
        logic digit_seen;
        logic optr_empty;
        logic opnd_ge2;
        logic opnd_one;
        logic top_lparen;
        logic top_prec_ge;
        logic code_lparen;
        logic code_div;
        logic b_zero;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic t_cls char_class(input logic [7:0] ch);
        t_cls cls;
        priority if (ch >= CH_ZERO && ch <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else if (ch == CH_SPACE) begin
            cls = CLS_SPACE;
        end else if (ch == CH_LF || ch == CH_CR) begin
            cls = CLS_LINE_END;
        end else if (ch == CH_LPAREN) begin
            cls = CLS_LPAREN;
        end else if (ch == CH_RPAREN) begin
            cls = CLS_RPAREN;
        end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
            cls = CLS_OPER;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

    function automatic t_op char_to_op(input logic [7:0] ch);
        t_op op;
        priority if (ch == CH_PLUS) begin
            op = OP_ADD;
        end else if (ch == CH_MINUS) begin
            op = OP_SUB;
        end else if (ch == CH_STAR) begin
            op = OP_MUL;
        end else if (ch == CH_SLASH) begin
            op = OP_DIV;
        end else begin
            op = OP_LPAREN;
        end
        return op;
    endfunction

    function automatic logic [1:0] op_prec(input t_op op);
        logic [1:0] p;
        priority if (op == OP_LPAREN) begin
            p = 2'd0;
        end else if (op == OP_ADD || op == OP_SUB) begin
            p = 2'd1;
        end else begin
            p = 2'd2;
        end
        return p;
    endfunction

endpackage

/* hdl/iee_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/iee_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module iee_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_d;
    logic        r_neg;
    logic [32:0] w_sh;
    logic        w_fit;

    assign w_sh  = {r_rem, r_q[31]};
    assign w_fit = w_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_d   <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            r_rem <= w_fit ? 32'(w_sh - {1'b0, r_d}) : w_sh[31:0];
            r_q   <= {r_q[30:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;

endmodule

/* hdl/iee_datapath.sv */
// Datapath: character register, number accumulator, both stacks, ALU, divider and result register.
module iee_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  iee_pkg::t_in  i_in,
    input  iee_pkg::t_cmd i_cmd,
    output iee_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output iee_pkg::t_out o_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]     r_ch;
    logic           r_last;
    iee_pkg::t_op   r_code;
    iee_pkg::t_op   r_apcode;
    logic [31:0]    r_accum;
    logic           r_digit;
    iee_pkg::t_err  r_err;
    logic [CW-1:0]  r_opnd_cnt;
    logic [CW-1:0]  r_optr_cnt;
    logic [31:0]    r_a;
    logic [31:0]    r_b;
    logic [31:0]    r_res;
    logic           r_out_valid;
    iee_pkg::t_out  r_out;

    logic           w_opnd_full;
    logic           w_optr_full;
    logic           w_opnd_we;
    logic [31:0]    w_opnd_wdata;
    logic [AW-1:0]  w_opnd_raddr;
    logic [31:0]    w_opnd_rdata;
    logic [CW-1:0]  w_opnd_top;
    logic [CW-1:0]  w_opnd_second;
    logic [CW-1:0]  w_optr_top;
    logic           w_optr_we;
    logic [2:0]     w_optr_rdata;
    iee_pkg::t_op   w_top_op;
    logic [31:0]    w_prod;
    logic [31:0]    w_quot;
    logic           w_div_done;
    logic           w_push_try;
    logic           w_out_free;

    assign w_opnd_full   = r_opnd_cnt >= CW'(STACK_DEPTH);
    assign w_optr_full   = r_optr_cnt >= CW'(STACK_DEPTH);
    assign w_opnd_top    = r_opnd_cnt - CW'(1);
    assign w_opnd_second = r_opnd_cnt - CW'(2);
    assign w_optr_top    = r_optr_cnt - CW'(1);
    assign w_opnd_we     = (i_cmd.flush || i_cmd.res_push) && !w_opnd_full;
    assign w_optr_we     = i_cmd.optr_push && !w_optr_full;
    assign w_opnd_wdata  = i_cmd.flush ? r_accum :
                           (r_apcode == iee_pkg::OP_DIV) ? w_quot : r_res;
    assign w_top_op      = iee_pkg::t_op'(w_optr_rdata);
    assign w_prod        = r_a * r_b;
    assign w_push_try    = i_cmd.flush || i_cmd.res_push || i_cmd.optr_push;
    assign w_out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.rd_sel)
            iee_pkg::RD_TOP:    w_opnd_raddr = w_opnd_top[AW-1:0];
            iee_pkg::RD_SECOND: w_opnd_raddr = w_opnd_second[AW-1:0];
            iee_pkg::RD_ZERO:   w_opnd_raddr = '0;
            default:            w_opnd_raddr = w_opnd_top[AW-1:0];
        endcase
    end

    iee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_opnd_ram (
        .i_clk   (i_clk),
        .i_we    (w_opnd_we),
        .i_waddr (r_opnd_cnt[AW-1:0]),
        .i_wdata (w_opnd_wdata),
        .i_raddr (w_opnd_raddr),
        .o_rdata (w_opnd_rdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_optr_ram (
        .i_clk   (i_clk),
        .i_we    (w_optr_we),
        .i_waddr (r_optr_cnt[AW-1:0]),
        .i_wdata (r_code),
        .i_raddr (w_optr_top[AW-1:0]),
        .o_rdata (w_optr_rdata)
    );

    iee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_digit     <= 1'b0;
            r_err       <= iee_pkg::ERR_NONE;
            r_opnd_cnt  <= '0;
            r_optr_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr_all) begin
                r_accum    <= '0;
                r_digit    <= 1'b0;
                r_err      <= iee_pkg::ERR_NONE;
                r_opnd_cnt <= '0;
                r_optr_cnt <= '0;
            end else begin
                if (i_cmd.accum) begin
                    r_accum <= (r_accum << 3) + (r_accum << 1) + {24'd0, r_ch - iee_pkg::CH_ZERO};
                    r_digit <= 1'b1;
                end else if (i_cmd.flush) begin
                    r_accum <= '0;
                    r_digit <= 1'b0;
                end
                if (r_err == iee_pkg::ERR_NONE) begin
                    if (i_cmd.raise != iee_pkg::ERR_NONE) begin
                        r_err <= i_cmd.raise;
                    end else if (w_push_try &&
                                 (((i_cmd.flush || i_cmd.res_push) && w_opnd_full) ||
                                  (i_cmd.optr_push && w_optr_full))) begin
                        r_err <= iee_pkg::ERR_OVERFLOW;
                    end
                end
                if (w_opnd_we) begin
                    r_opnd_cnt <= r_opnd_cnt + CW'(1);
                end else if (i_cmd.opnd_pop2) begin
                    r_opnd_cnt <= w_opnd_second;
                end
                if (w_optr_we) begin
                    r_optr_cnt <= r_optr_cnt + CW'(1);
                end else if (i_cmd.optr_pop) begin
                    r_optr_cnt <= w_optr_top;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch   <= i_in.ch;
            r_last <= i_in.last;
        end
        if (i_cmd.load_code) begin
            r_code <= iee_pkg::char_to_op(r_ch);
        end
        if (i_cmd.optr_pop) begin
            r_apcode <= w_top_op;
        end
        if (i_cmd.lat_b) begin
            r_b <= w_opnd_rdata;
        end
        if (i_cmd.lat_a) begin
            r_a <= w_opnd_rdata;
        end
        if (i_cmd.exec) begin
            unique case (r_apcode)
                iee_pkg::OP_ADD: r_res <= r_a + r_b;
                iee_pkg::OP_SUB: r_res <= r_a - r_b;
                default:         r_res <= w_prod;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.value <= (r_err == iee_pkg::ERR_NONE) ? w_opnd_rdata : '0;
            r_out.error <= r_err;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.cls         = iee_pkg::char_class(r_ch);
        o_sts.last        = r_last;
        o_sts.err_set     = r_err != iee_pkg::ERR_NONE;
        o_sts.digit_seen  = r_digit;
        o_sts.optr_empty  = r_optr_cnt == '0;
        o_sts.opnd_ge2    = r_opnd_cnt >= CW'(2);
        o_sts.opnd_one    = r_opnd_cnt == CW'(1);
        o_sts.top_lparen  = w_top_op == iee_pkg::OP_LPAREN;
        o_sts.top_prec_ge = iee_pkg::op_prec(w_top_op) >= iee_pkg::op_prec(r_code);
        o_sts.code_lparen = r_apcode == iee_pkg::OP_LPAREN;
        o_sts.code_div    = r_apcode == iee_pkg::OP_DIV;
        o_sts.b_zero      = r_b == '0;
        o_sts.div_done    = w_div_done;
        o_sts.out_free    = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_opnd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_opnd_cnt <= CW'(STACK_DEPTH))
        else $error("Operand count exceeds the stack depth.");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != iee_pkg::ERR_NONE && !i_cmd.clr_all) |=> r_err == $past(r_err))
        else $error("Latched error changed before the expression ended.");

    a_result_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_push |-> !w_opnd_full)
        else $error("Operator result pushed onto a full operand stack.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("Result register overwritten before its transaction.");

endmodule

/* hdl/iee_ctrl.sv */
// Controller state machine that sequences character handling, operator reduction and the result.
module iee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iee_pkg::t_sts i_sts,
    output iee_pkg::t_cmd o_cmd
);

    iee_pkg::t_state r_state;
    iee_pkg::t_state n_state;
    iee_pkg::t_state r_ret;
    iee_pkg::t_state n_ret;
    logic            r_fin;
    logic            n_fin;
    iee_pkg::t_state w_after;

    assign w_after = i_sts.last ? iee_pkg::ST_FIN : iee_pkg::ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iee_pkg::ST_IDLE;
            r_ret   <= iee_pkg::ST_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fin   = r_fin;
        unique case (r_state)
            iee_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = iee_pkg::ST_DECODE;
                end
            end
            iee_pkg::ST_DECODE: begin
                priority if (i_sts.cls == iee_pkg::CLS_LINE_END) begin
                    n_state = iee_pkg::ST_FIN;
                end else if (i_sts.err_set || i_sts.cls == iee_pkg::CLS_SPACE ||
                             i_sts.cls == iee_pkg::CLS_DIGIT) begin
                    n_state = w_after;
                end else if (i_sts.digit_seen) begin
                    n_state = iee_pkg::ST_FLUSH;
                end else begin
                    n_state = iee_pkg::ST_DISPATCH;
                end
            end
            iee_pkg::ST_FLUSH: begin
                n_state = r_fin ? iee_pkg::ST_FN_CHK : iee_pkg::ST_DISPATCH;
            end
            iee_pkg::ST_DISPATCH: begin
                priority if (i_sts.err_set) begin
                    n_state = w_after;
                end else if (i_sts.cls == iee_pkg::CLS_RPAREN) begin
                    n_state = iee_pkg::ST_CL_CHK;
                end else if (i_sts.cls == iee_pkg::CLS_LPAREN) begin
                    n_state = iee_pkg::ST_OPUSH;
                end else if (i_sts.cls == iee_pkg::CLS_OPER) begin
                    n_state = iee_pkg::ST_OP_CHK;
                end else begin
                    n_state = w_after;
                end
            end
            iee_pkg::ST_OP_CHK: begin
                n_state = (i_sts.err_set || i_sts.optr_empty) ? iee_pkg::ST_OPUSH
                                                              : iee_pkg::ST_OP_RD;
            end
            iee_pkg::ST_OP_RD: begin
                if (i_sts.top_prec_ge) begin
                    n_ret   = iee_pkg::ST_OP_CHK;
                    n_state = iee_pkg::ST_AP_CHK;
                end else begin
                    n_state = iee_pkg::ST_OPUSH;
                end
            end
            iee_pkg::ST_OPUSH: begin
                n_state = w_after;
            end
            iee_pkg::ST_CL_CHK: begin
                n_state = (i_sts.err_set || i_sts.optr_empty) ? w_after : iee_pkg::ST_CL_RD;
            end
            iee_pkg::ST_CL_RD: begin
                if (i_sts.top_lparen) begin
                    n_state = w_after;
                end else begin
                    n_ret   = iee_pkg::ST_CL_CHK;
                    n_state = iee_pkg::ST_AP_CHK;
                end
            end
            iee_pkg::ST_FIN: begin
                n_fin = 1'b1;
                priority if (i_sts.err_set) begin
                    n_state = iee_pkg::ST_FIN_END;
                end else if (i_sts.digit_seen) begin
                    n_state = iee_pkg::ST_FLUSH;
                end else begin
                    n_state = iee_pkg::ST_FN_CHK;
                end
            end
            iee_pkg::ST_FN_CHK: begin
                n_state = (i_sts.err_set || i_sts.optr_empty) ? iee_pkg::ST_FIN_END
                                                              : iee_pkg::ST_FN_RD;
            end
            iee_pkg::ST_FN_RD: begin
                n_ret   = iee_pkg::ST_FN_CHK;
                n_state = iee_pkg::ST_AP_CHK;
            end
            iee_pkg::ST_FIN_END: begin
                n_state = iee_pkg::ST_FIN_RD;
            end
            iee_pkg::ST_FIN_RD: begin
                if (i_sts.out_free) begin
                    n_fin   = 1'b0;
                    n_state = iee_pkg::ST_IDLE;
                end
            end
            iee_pkg::ST_AP_CHK: begin
                n_state = (i_sts.code_lparen || !i_sts.opnd_ge2) ? r_ret : iee_pkg::ST_AP_RB;
            end
            iee_pkg::ST_AP_RB: begin
                n_state = iee_pkg::ST_AP_RA;
            end
            iee_pkg::ST_AP_RA: begin
                n_state = iee_pkg::ST_AP_EXE;
            end
            iee_pkg::ST_AP_EXE: begin
                priority if (i_sts.code_div && i_sts.b_zero) begin
                    n_state = r_ret;
                end else if (i_sts.code_div) begin
                    n_state = iee_pkg::ST_AP_DIV;
                end else begin
                    n_state = iee_pkg::ST_AP_PUSH;
                end
            end
            iee_pkg::ST_AP_DIV: begin
                if (i_sts.div_done) begin
                    n_state = iee_pkg::ST_AP_PUSH;
                end
            end
            iee_pkg::ST_AP_PUSH: begin
                n_state = r_ret;
            end
            default: begin
                n_state = iee_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = iee_pkg::RD_TOP;
        o_cmd.raise  = iee_pkg::ERR_NONE;
        o_in_ready   = 1'b0;
        unique case (r_state)
            iee_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            iee_pkg::ST_DECODE: begin
                o_cmd.accum     = !i_sts.err_set && i_sts.cls == iee_pkg::CLS_DIGIT;
                o_cmd.load_code = 1'b1;
            end
            iee_pkg::ST_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
            iee_pkg::ST_DISPATCH: begin
                if (!i_sts.err_set && i_sts.cls == iee_pkg::CLS_BAD) begin
                    o_cmd.raise = iee_pkg::ERR_BADCHAR;
                end
            end
            iee_pkg::ST_OP_RD: begin
                o_cmd.optr_pop = i_sts.top_prec_ge;
            end
            iee_pkg::ST_OPUSH: begin
                o_cmd.optr_push = !i_sts.err_set;
            end
            iee_pkg::ST_CL_CHK: begin
                if (!i_sts.err_set && i_sts.optr_empty) begin
                    o_cmd.raise = iee_pkg::ERR_MALFORMED;
                end
            end
            iee_pkg::ST_CL_RD: begin
                o_cmd.optr_pop = 1'b1;
            end
            iee_pkg::ST_FN_RD: begin
                o_cmd.optr_pop = 1'b1;
            end
            iee_pkg::ST_FIN_END: begin
                o_cmd.rd_sel = iee_pkg::RD_ZERO;
                if (!i_sts.err_set && !i_sts.opnd_one) begin
                    o_cmd.raise = iee_pkg::ERR_MALFORMED;
                end
            end
            iee_pkg::ST_FIN_RD: begin
                o_cmd.rd_sel   = iee_pkg::RD_ZERO;
                o_cmd.out_load = i_sts.out_free;
                o_cmd.clr_all  = i_sts.out_free;
            end
            iee_pkg::ST_AP_CHK: begin
                if (i_sts.code_lparen || !i_sts.opnd_ge2) begin
                    o_cmd.raise = iee_pkg::ERR_MALFORMED;
                end
            end
            iee_pkg::ST_AP_RB: begin
                o_cmd.lat_b  = 1'b1;
                o_cmd.rd_sel = iee_pkg::RD_SECOND;
            end
            iee_pkg::ST_AP_RA: begin
                o_cmd.lat_a     = 1'b1;
                o_cmd.opnd_pop2 = 1'b1;
            end
            iee_pkg::ST_AP_EXE: begin
                if (i_sts.code_div && i_sts.b_zero) begin
                    o_cmd.raise = iee_pkg::ERR_DIV0;
                end
                o_cmd.div_start = i_sts.code_div && !i_sts.b_zero;
                o_cmd.exec      = !i_sts.code_div;
            end
            iee_pkg::ST_AP_PUSH: begin
                o_cmd.res_push = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == iee_pkg::ST_IDLE)
        else $error("Input taken outside the idle state.");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == iee_pkg::ST_DECODE)
        else $error("Accepted transaction was not decoded.");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iee_pkg::ST_FIN_RD && i_sts.out_free) |=> !r_fin)
        else $error("Finish mode survived the result.");

endmodule

/* hdl/infix_expression_evaluator.sv */
// Top level of the two-stack infix expression evaluator.
// Each character is taken in the idle state and then decoded; an operator or parenthesis may
// trigger reductions, and a division reduction waits for the bit-serial divider. The result
// transaction follows the last character once the reductions left on the stack are done,
// and waits while the receiver stalls.
// Synchronous active-low reset clears the counts, accumulator, error and handshake state.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iee_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output iee_pkg::t_out o_out
);

    iee_pkg::t_cmd w_cmd;
    iee_pkg::t_sts w_sts;

    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* verif/infix_expression_evaluator_checker.sv */
`timescale 1ns / 100ps
// Checker for the infix expression evaluator: predicts results from the input stream and compares.
module infix_expression_evaluator_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  iee_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  iee_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_results_seen
);

    logic [31:0]   vals[STACK_DEPTH];
    iee_pkg::t_op  ops[STACK_DEPTH];
    int            val_count;
    int            op_count;
    logic [31:0]   accum;
    logic          have_digit;
    iee_pkg::t_err err;
    iee_pkg::t_out expected_results[$];

    function automatic logic [1:0] prec_of(iee_pkg::t_op op);
        if (op == iee_pkg::OP_LPAREN) return 2'd0;
        if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 2'd1;
        return 2'd2;
    endfunction

    task automatic flag(iee_pkg::t_err e);
        if (err == iee_pkg::ERR_NONE) err = e;
    endtask

    task automatic push_val(logic [31:0] v);
        if (val_count >= STACK_DEPTH) flag(iee_pkg::ERR_OVERFLOW);
        else begin
            vals[val_count] = v;
            val_count++;
        end
    endtask

    task automatic push_op(iee_pkg::t_op op);
        if (op_count >= STACK_DEPTH) flag(iee_pkg::ERR_OVERFLOW);
        else begin
            ops[op_count] = op;
            op_count++;
        end
    endtask

    task automatic reduce(iee_pkg::t_op op);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0] r;
        if (op == iee_pkg::OP_LPAREN || val_count < 2) begin
            flag(iee_pkg::ERR_MALFORMED);
            return;
        end
        b = vals[val_count - 1];
        a = vals[val_count - 2];
        val_count -= 2;
        case (op)
            iee_pkg::OP_ADD: r = a + b;
            iee_pkg::OP_SUB: r = a - b;
            iee_pkg::OP_MUL: r = a * b;
            default: begin
                if (b == 0) begin
                    flag(iee_pkg::ERR_DIV0);
                    return;
                end
                if (a == 32'sh8000_0000 && b == -32'sd1) r = a;
                else r = a / b;
            end
        endcase
        push_val(r);
    endtask

    task automatic flush_number();
        if (have_digit) begin
            push_val(accum);
            accum = '0;
            have_digit = 1'b0;
        end
    endtask

    task automatic take_operator(iee_pkg::t_op op);
        if (op != iee_pkg::OP_LPAREN) begin
            while (err == iee_pkg::ERR_NONE && op_count > 0 &&
                   prec_of(ops[op_count - 1]) >= prec_of(op)) begin
                op_count--;
                reduce(ops[op_count]);
            end
        end
        if (err == iee_pkg::ERR_NONE) push_op(op);
    endtask

    task automatic close_paren();
        iee_pkg::t_op op;
        forever begin
            if (err != iee_pkg::ERR_NONE) return;
            if (op_count == 0) begin
                flag(iee_pkg::ERR_MALFORMED);
                return;
            end
            op_count--;
            op = ops[op_count];
            if (op == iee_pkg::OP_LPAREN) return;
            reduce(op);
        end
    endtask

    task automatic clear_state();
        val_count = 0;
        op_count = 0;
        accum = '0;
        have_digit = 1'b0;
        err = iee_pkg::ERR_NONE;
    endtask

    task automatic end_expression();
        iee_pkg::t_out res;
        iee_pkg::t_op op;
        if (err == iee_pkg::ERR_NONE) flush_number();
        while (err == iee_pkg::ERR_NONE && op_count > 0) begin
            op_count--;
            op = ops[op_count];
            reduce(op);
        end
        if (err == iee_pkg::ERR_NONE && val_count != 1) flag(iee_pkg::ERR_MALFORMED);
        res.value = (err == iee_pkg::ERR_NONE) ? vals[0] : '0;
        res.error = err;
        expected_results.push_back(res);
        clear_state();
    endtask

    task automatic consume_char(logic [7:0] c);
        if (c == iee_pkg::CH_SPACE) return;
        if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
            accum = accum * 32'd10 + 32'(c - iee_pkg::CH_ZERO);
            have_digit = 1'b1;
            return;
        end
        flush_number();
        if (err != iee_pkg::ERR_NONE) return;
        case (c)
            iee_pkg::CH_RPAREN: close_paren();
            iee_pkg::CH_LPAREN: take_operator(iee_pkg::OP_LPAREN);
            iee_pkg::CH_PLUS:   take_operator(iee_pkg::OP_ADD);
            iee_pkg::CH_MINUS:  take_operator(iee_pkg::OP_SUB);
            iee_pkg::CH_STAR:   take_operator(iee_pkg::OP_MUL);
            iee_pkg::CH_SLASH:  take_operator(iee_pkg::OP_DIV);
            default:            flag(iee_pkg::ERR_BADCHAR);
        endcase
    endtask

    always @(posedge i_clk) begin
        iee_pkg::t_out want;
        int fails;
        if (!i_rst_n) begin
            clear_state();
            expected_results.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_pending <= 0;
        end else begin
            fails = 0;
            if (i_out_valid && i_out_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("Unexpected result transaction: value %0d error %0d",
                           i_out.value, i_out.error);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.value !== want.value) begin
                        $error("Field value: expected %0d, actual %0d", want.value, i_out.value);
                        fails++;
                    end
                    if (i_out.error !== want.error) begin
                        $error("Field error: expected %0d, actual %0d", want.error, i_out.error);
                        fails++;
                    end
                end
            end
            o_fail_count <= o_fail_count + fails;
            if (i_in_valid && i_in_ready) begin
                if (i_in.ch == iee_pkg::CH_LF || i_in.ch == iee_pkg::CH_CR) end_expression();
                else begin
                    if (err == iee_pkg::ERR_NONE) consume_char(i_in.ch);
                    if (i_in.last) end_expression();
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

/* verif/infix_expression_evaluator_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the infix expression evaluator: stimulus, idling and the verdict.
module infix_expression_evaluator_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int STACK_DEPTH_TB = 65;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    iee_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_ready;
    iee_pkg::t_out o_out;
    int            fail_count;
    int            pending;
    int            results_seen;
    int            chars_sent;
    int            idle_cycles;
    int            burst_left;
    byte           expr[$];

    infix_expression_evaluator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    infix_expression_evaluator_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 9) != 0);
                2: i_out_ready <= ($urandom_range(0, 2) == 0);
                default: i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d idle cycles.", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_char(byte c, bit is_last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 20);
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 1 : 0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in.ch <= c;
        i_in.last <= is_last;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(string s, bit end_with_last);
        for (int k = 0; k < s.len(); k++) send_char(s[k], end_with_last && k == s.len() - 1);
    endtask

    task automatic send_expr();
        int mode;
        mode = $urandom_range(0, 5);
        foreach (expr[k]) begin
            if (k != expr.size() - 1) send_char(expr[k], 1'b0);
            else if (mode == 0) send_char(iee_pkg::CH_LF, 1'b0);
            else if (mode == 1) send_char(iee_pkg::CH_CR, 1'b1);
            else if (mode == 2) begin
                send_char(expr[k], 1'b0);
                send_char(iee_pkg::CH_CR, 1'b0);
            end else send_char(expr[k], 1'b1);
        end
    endtask

    function automatic byte rand_operator();
        case ($urandom_range(0, 3))
            0: return iee_pkg::CH_PLUS;
            1: return iee_pkg::CH_MINUS;
            2: return iee_pkg::CH_STAR;
            default: return iee_pkg::CH_SLASH;
        endcase
    endfunction

    task automatic add_number();
        int digits;
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        for (int k = 0; k < digits; k++) begin
            expr.push_back(byte'(iee_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic add_term(int depth);
        if ($urandom_range(0, 5) == 0) expr.push_back(iee_pkg::CH_SPACE);
        if (depth < 6 && $urandom_range(0, 3) == 0) begin
            expr.push_back(iee_pkg::CH_LPAREN);
            add_sum(depth + 1);
            expr.push_back(iee_pkg::CH_RPAREN);
        end else add_number();
    endtask

    task automatic add_sum(int depth);
        int n;
        n = $urandom_range(0, 4 - (depth > 3 ? 3 : depth));
        add_term(depth);
        for (int k = 0; k < n; k++) begin
            expr.push_back(rand_operator());
            add_term(depth);
        end
    endtask

    task automatic build_expr();
        int pick;
        expr.delete();
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
            add_sum(0);
        end else if (pick < 18) begin
            add_sum(0);
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0: expr.insert($urandom_range(0, expr.size()), rand_operator());
                    1: expr.insert($urandom_range(0, expr.size()), iee_pkg::CH_LPAREN);
                    2: expr.insert($urandom_range(0, expr.size()), iee_pkg::CH_RPAREN);
                    default: expr.insert($urandom_range(0, expr.size()),
                                         byte'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 6)) expr.push_back(byte'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int wait_cycles;
        string deep;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        chars_sent = 0;
        burst_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("2147483647+1", 1'b1);
        send_text("(0-2147483647-1)/(0-1)", 1'b1);
        send_text("4294967296*7 - 8/0", 1'b1);
        send_text("((1+2)*3", 1'b1);
        send_text("1+2)", 1'b1);
        send_text(" ", 1'b1);
        send_text("3 4", 1'b1);
        send_text("+", 1'b1);
        send_text("7-9/2*3", 1'b1);
        send_text("0-7/2", 1'b1);
        send_text("5#", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b1);
        send_char(iee_pkg::CH_LF, 1'b1);
        send_text("12\n", 1'b0);
        deep = "";
        for (int k = 0; k < STACK_DEPTH_TB; k++) deep = {deep, "("};
        send_text({deep, "1"}, 1'b1);

        while (chars_sent < 1650) begin
            build_expr();
            send_expr();
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while ((pending != 0 || o_out_valid) && wait_cycles < 50000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        $display("Sent %0d characters, checked %0d expression results.", chars_sent,
                 results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
